[rtl/core/rld_pkg.sv]
// Shared constants, types and helpers for the run-length digit encoder.
package rld_pkg;

    localparam int MAX_RUN       = 9;
    localparam int LITERAL_LIMIT = 3;
    localparam int COUNT_W       = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // One queued transaction group: the bytes caused by one input byte.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            is_end;
    } t_entry;

    function automatic logic [7:0] digit_of(input logic [COUNT_W-1:0] k);
        digit_of = ASCII_ZERO + {{(8 - COUNT_W){1'b0}}, k};
    endfunction

endpackage

[rtl/core/rld_front.sv]
// Front end: tracks the open run and turns each input byte into a queue entry.
module rld_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_q_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_ready,
    output logic                  o_push,
    output rld_pkg::t_entry       o_entry
);

    logic [7:0]                   r_held_char, n_held_char;
    logic [rld_pkg::COUNT_W-1:0]  r_run_count, n_run_count;
    logic                         r_holding, n_holding;

    logic                         same;
    logic [rld_pkg::COUNT_W-1:0]  inc;
    logic [rld_pkg::COUNT_W-1:0]  fk;
    logic [1:0]                   fl_n;
    logic [7:0]                   fl0, fl1;
    logic                         accept;
    rld_pkg::t_entry              ent;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        same = r_holding && (i_byte == r_held_char);
        inc  = r_run_count + rld_pkg::COUNT_W'(1);
        fk   = same ? inc : r_run_count;

        // Remainder flush of the held run with count fk.
        fl0 = r_held_char;
        fl1 = r_held_char;
        if (!r_holding || fk == '0) begin
            fl_n = 2'd0;
        end else if (fk < rld_pkg::COUNT_W'(rld_pkg::LITERAL_LIMIT)) begin
            fl_n = fk[1:0];
        end else begin
            fl_n = 2'd2;
            fl1  = rld_pkg::digit_of(fk);
        end

        ent.bytes  = {8'h00, fl1, fl0};
        ent.cnt    = 2'd0;
        ent.is_end = i_last;

        n_held_char = r_held_char;
        n_run_count = r_run_count;
        n_holding   = r_holding;

        if (same) begin
            if (inc == rld_pkg::COUNT_W'(rld_pkg::MAX_RUN)) begin
                // A full chunk goes out at once; the run stays open and empty.
                ent.bytes   = {8'h00,
                               rld_pkg::digit_of(rld_pkg::COUNT_W'(rld_pkg::MAX_RUN)),
                               r_held_char};
                ent.cnt     = 2'd2;
                n_run_count = '0;
            end else begin
                ent.cnt     = i_last ? fl_n : 2'd0;
                n_run_count = inc;
            end
        end else begin
            ent.cnt = fl_n;
            if (i_last) begin
                ent.bytes[fl_n] = i_byte;
                ent.cnt         = fl_n + 2'd1;
            end
            n_held_char = i_byte;
            n_holding   = 1'b1;
            n_run_count = rld_pkg::COUNT_W'(1);
        end

        if (i_last) begin
            n_held_char = '0;
            n_run_count = '0;
            n_holding   = 1'b0;
        end
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_char <= '0;
            r_run_count <= '0;
            r_holding   <= 1'b0;
        end else if (accept) begin
            r_held_char <= n_held_char;
            r_run_count <= n_run_count;
            r_holding   <= n_holding;
        end
    end

endmodule

[rtl/core/rld_queue.sv]
// Small register queue between the front end and the output serializer.
module rld_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rld_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_not_full,
    output logic            o_not_empty,
    output rld_pkg::t_entry o_head
);

    rld_pkg::t_entry                r_mem [rld_pkg::QUEUE_DEPTH];
    logic [rld_pkg::QPTR_W-1:0]     r_wr, n_wr;
    logic [rld_pkg::QPTR_W-1:0]     r_rd, n_rd;
    logic [rld_pkg::QFILL_W-1:0]    r_fill, n_fill;
    logic                           do_push, do_pop;

    assign o_not_full  = (r_fill != rld_pkg::QFILL_W'(rld_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_fill != '0);
    assign o_head      = r_mem[r_rd];

    assign do_push = i_push && o_not_full;
    assign do_pop  = i_pop && o_not_empty;

    always_comb begin
        n_wr   = do_push ? r_wr + rld_pkg::QPTR_W'(1) : r_wr;
        n_rd   = do_pop  ? r_rd + rld_pkg::QPTR_W'(1) : r_rd;
        n_fill = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + rld_pkg::QFILL_W'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - rld_pkg::QFILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[rtl/core/rld_back.sv]
// Back end: sends the bytes of the head queue entry one transaction at a time.
module rld_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_have,
    input  rld_pkg::t_entry i_head,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic            o_end,
    output logic            o_pop
);

    logic [1:0] r_pos, n_pos;
    logic       fire;

    assign o_valid = i_have;
    assign o_byte  = i_head.bytes[r_pos];
    assign o_last  = (r_pos == i_head.cnt - 2'd1);
    assign o_end   = o_last && i_head.is_end;
    assign fire    = i_have && i_ready;
    assign o_pop   = fire && o_last;

    always_comb begin
        n_pos = r_pos;
        if (fire) begin
            n_pos = o_last ? 2'd0 : r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

[rtl/core/run_length_digit_encoder.sv]
// Top level of the run-length digit encoder: front end, entry queue, serializer.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_byte, i_in_last
//   out     | output    | o_out_valid / i_out_ready  | o_out_byte, o_out_last, o_out_end
//
// The front end takes one input transaction per cycle while the four-entry queue has room.
// Each input byte causes zero to three output bytes, which the serializer sends at one
// output transaction per ready cycle, so sustained throughput is set by the output byte count.
// Reset (synchronous, active low) clears the open run, the queue pointers and the serializer.
// A stalled output fills the queue; the input then stalls only once all four entries are taken.
module run_length_digit_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_end
);

    // Link between the stages: entries pushed by the front end, popped by the back end.
    rld_pkg::t_entry push_entry;
    rld_pkg::t_entry head_entry;
    logic            push;
    logic            pop;
    logic            q_not_full;
    logic            q_not_empty;

    // The front end keeps the held byte and run count and classifies each byte
    // into the group of output bytes it causes. Bytes that cause nothing
    // update the run and never reach the queue.
    rld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_q_ready (q_not_full),
        .i_byte    (i_in_byte),
        .i_last    (i_in_last),
        .o_ready   (o_in_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // The queue decouples the two sides so that output bursts do not stall input while it has room.
    rld_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .i_pop       (pop),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_head      (head_entry)
    );

    // The back end walks through the head entry, marking its final byte with
    // o_out_last, and with o_out_end when the entry closes the message.
    rld_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_have  (q_not_empty),
        .i_head  (head_entry),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_byte  (o_out_byte),
        .o_last  (o_out_last),
        .o_end   (o_out_end),
        .o_pop   (pop)
    );

endmodule

[tb/sv/tb_run_length_digit_encoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the run-length digit encoder: directed table, random messages, scoreboard.
module tb_run_length_digit_encoder;

    // Cycles without any transaction on either channel before the run is declared hung.
    // The longest legal quiet stretch is the deliberate output hold-off below.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES = 20;

    // One output byte as it should appear on the out channel.
    typedef struct packed {
        logic [7:0] data;
        logic       grp_last;
        logic       msg_end;
    } t_enc_byte;

    // One input transaction. When use_typed is set, the expected output group is
    // typed into the row by hand instead of being taken from the encoder model.
    typedef struct packed {
        logic [7:0]            data;
        logic                  msg_last;
        logic                  use_typed;
        logic [1:0]            n_typed;
        t_enc_byte [2:0]       typed;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_out_end;

    run_length_digit_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_end   (o_out_end)
    );

    // Output bytes still owed by the block, oldest first.
    t_enc_byte expected_bytes[$];
    // Output group produced by the encoder model for the latest input byte.
    t_enc_byte group_bytes[$];
    t_stim_row directed_rows[$];

    // Encoder model state: byte of the open run, unreported copies, run open flag.
    logic [7:0] open_char;
    logic [3:0] open_count;
    logic       run_active;

    int errors;
    int items_sent;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------------------
    // Encoder model. Each input byte either extends the open run or flushes it and opens a
    // new one. A run that reaches MAX_RUN copies is reported at once as the byte and the
    // digit of MAX_RUN. A flushed remainder of one or two copies goes out as literals, a
    // larger one as the byte and its ASCII digit. The flagged final byte flushes whatever
    // is open and returns the model to its reset state.
    // ------------------------------------------------------------------------------------
    function automatic void emit_byte(input logic [7:0] d);
        group_bytes.push_back({d, 1'b0, 1'b0});
    endfunction

    function automatic void flush_open_run();
        if (run_active && open_count != 0) begin
            if (open_count < rld_pkg::LITERAL_LIMIT) begin
                for (int i = 0; i < open_count; i++) emit_byte(open_char);
            end else begin
                emit_byte(open_char);
                emit_byte(8'(rld_pkg::ASCII_ZERO + {4'h0, open_count}));
            end
        end
        open_count = '0;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic is_last);
        t_enc_byte tail;
        int        idx;
        group_bytes.delete();
        if (run_active && b == open_char) begin
            open_count = open_count + 4'd1;
        end else begin
            flush_open_run();
            open_char  = b;
            run_active = 1'b1;
            open_count = 4'd1;
        end
        if (open_count >= rld_pkg::MAX_RUN) begin
            emit_byte(open_char);
            emit_byte(8'(rld_pkg::ASCII_ZERO + rld_pkg::MAX_RUN));
            open_count = '0;
        end
        if (is_last) begin
            flush_open_run();
            open_char  = '0;
            open_count = '0;
            run_active = 1'b0;
        end
        // The last byte of a group carries grp_last, and on a flagged input also msg_end.
        if (group_bytes.size() > 0) begin
            idx = group_bytes.size() - 1;
            tail = group_bytes[idx];
            tail.grp_last = 1'b1;
            tail.msg_end = is_last;
            group_bytes[idx] = tail;
        end
    endfunction

    function automatic t_stim_row mk_row(input logic [7:0] b, input logic is_last,
                                         input logic typed, input int n,
                                         input t_enc_byte e0, input t_enc_byte e1,
                                         input t_enc_byte e2);
        t_stim_row r;
        r.data = b;
        r.msg_last = is_last;
        r.use_typed = typed;
        r.n_typed = 2'(n);
        r.typed[0] = e0;
        r.typed[1] = e1;
        r.typed[2] = e2;
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Input driver. Called at a falling edge; leaves at a falling edge. The expected group
    // is queued when the byte is first offered: bytes are accepted in order, and the block
    // cannot answer a byte before accepting it, so this never races the output check.
    // ------------------------------------------------------------------------------------
    task automatic send_byte(input t_stim_row r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        encode_byte(r.data, r.msg_last);
        if (r.use_typed) begin
            for (int i = 0; i < r.n_typed; i++) expected_bytes.push_back(r.typed[i]);
        end else begin
            foreach (group_bytes[i]) expected_bytes.push_back(group_bytes[i]);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= r.data;
        i_in_last  <= r.msg_last;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // One random message. Most messages are built from runs over a small per-message
    // alphabet, so runs merge, reach full chunks and run past two chunks. The rest are
    // short strings of unrelated bytes.
    task automatic send_message();
        logic [7:0] alpha [4];
        logic [7:0] b;
        int         n_runs;
        int         seg_len;
        int         pick;
        bit         noise;
        noise = ($urandom_range(0, 99) < 15);
        for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
        if (noise) begin
            seg_len = $urandom_range(1, 6);
            for (int j = 0; j < seg_len; j++) begin
                send_byte(mk_row(8'($urandom_range(0, 255)), j == seg_len - 1,
                                 1'b0, 0, '0, '0, '0));
            end
        end else begin
            n_runs = $urandom_range(1, 5);
            for (int i = 0; i < n_runs; i++) begin
                if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
                else b = alpha[$urandom_range(0, 3)];
                pick = $urandom_range(0, 99);
                if (pick < 50) seg_len = $urandom_range(1, 3);
                else if (pick < 85) seg_len = $urandom_range(4, 9);
                else seg_len = $urandom_range(10, 20);
                for (int j = 0; j < seg_len; j++) begin
                    send_byte(mk_row(b, (i == n_runs - 1) && (j == seg_len - 1),
                                     1'b0, 0, '0, '0, '0));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Output side back-pressure. Ready changes at the falling edge only. A hold-off request
    // from the stimulus forces ready low for a counted stretch, long enough for the entry
    // queue to fill and the input channel to stall.
    // ------------------------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Every output transaction is matched field by field against the oldest expectation.
    always @(posedge i_clk) begin
        t_enc_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output byte %h last %b end %b", $time,
                         o_out_byte, o_out_last, o_out_end);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.data, o_out_byte);
                    errors++;
                end
                if (o_out_last !== want.grp_last) begin
                    $display("%0t: out_last expected %b actual %b", $time,
                             want.grp_last, o_out_last);
                    errors++;
                end
                if (o_out_end !== want.msg_end) begin
                    $display("%0t: out_end expected %b actual %b", $time,
                             want.msg_end, o_out_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts consecutive cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_run_length_digit_encoder: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = '0;
        i_in_last = 1'b0;
        errors = 0;
        items_sent = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        open_char = '0;
        open_count = '0;
        run_active = 1'b0;

        // Directed table. Rows with typed groups are the ones whose output is plain to see:
        // single-byte messages, a full chunk of nine, literal and digit flushes.
        // Two single-byte messages in a row: the end of a message clears the open run.
        directed_rows.push_back(mk_row(8'h00, 1'b1, 1'b1, 1, {8'h00, 1'b1, 1'b1}, '0, '0));
        directed_rows.push_back(mk_row(8'h00, 1'b1, 1'b1, 1, {8'h00, 1'b1, 1'b1}, '0, '0));
        // Eight copies produce nothing; the ninth completes a chunk, reported at once.
        for (int i = 0; i < 8; i++)
            directed_rows.push_back(mk_row(8'h41, 1'b0, 1'b0, 0, '0, '0, '0));
        directed_rows.push_back(mk_row(8'h41, 1'b0, 1'b1, 2, {8'h41, 1'b0, 1'b0},
                                       {8'h39, 1'b1, 1'b0}, '0));
        // After a full chunk the run is open with nothing owed, so a new byte flushes nothing.
        directed_rows.push_back(mk_row(8'hFF, 1'b1, 1'b1, 1, {8'hFF, 1'b1, 1'b1}, '0, '0));
        // A run of three goes out as byte and digit, ahead of the final byte.
        for (int i = 0; i < 3; i++)
            directed_rows.push_back(mk_row(8'h55, 1'b0, 1'b0, 0, '0, '0, '0));
        directed_rows.push_back(mk_row(8'hAA, 1'b1, 1'b1, 3, {8'h55, 1'b0, 1'b0},
                                       {8'h33, 1'b0, 1'b0}, {8'hAA, 1'b1, 1'b1}));
        // Runs of two go out as two literals, both on a new byte and at the end.
        directed_rows.push_back(mk_row(8'h12, 1'b0, 1'b0, 0, '0, '0, '0));
        directed_rows.push_back(mk_row(8'h12, 1'b0, 1'b0, 0, '0, '0, '0));
        directed_rows.push_back(mk_row(8'h34, 1'b0, 1'b1, 2, {8'h12, 1'b0, 1'b0},
                                       {8'h12, 1'b1, 1'b0}, '0));
        directed_rows.push_back(mk_row(8'h34, 1'b1, 1'b1, 2, {8'h34, 1'b0, 1'b0},
                                       {8'h34, 1'b1, 1'b1}, '0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_byte(directed_rows[i]);

        // Random messages over four handshake phases: free-running, sparse input,
        // stalled output, and light idling on both sides.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) send_message();
        end

        // Long output hold-off while the input keeps offering bytes: the entry queue
        // fills up and the input channel has to stall until the output drains.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        for (int j = 0; j < 24; j++)
            send_byte(mk_row(8'($urandom_range(0, 255)), j == 23, 1'b0, 0, '0, '0, '0));
        i_in_valid <= 1'b0;

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_run_length_digit_encoder: PASS");
        end else begin
            $display("tb_run_length_digit_encoder: FAIL");
        end
        $finish;
    end

endmodule

[run_length_digit_encoder.f]
rtl/core/rld_pkg.sv
rtl/core/rld_front.sv
rtl/core/rld_queue.sv
rtl/core/rld_back.sv
rtl/core/run_length_digit_encoder.sv
tb/sv/tb_run_length_digit_encoder.sv
